// File: rtl/core/mtdl_pkg.sv
// Package for the multitap delay line: register map, field widths and
// reset values. Has no dependencies; imported by multitap_delay_line.
package mtdl_pkg;

    localparam int DEFAULT_BUFFER_DEPTH = 65536;
    localparam int DEFAULT_MAX_TAPS     = 3;
    localparam int DEFAULT_SAMPLE_BITS  = 24;

    localparam int NUM_TAP_REGS   = 3;
    localparam int GAIN_BITS      = 20;
    localparam int GAIN_FRAC_BITS = 16;
    localparam int DELAY_BITS     = 16;
    localparam int BUF_LEN_BITS   = 17;
    localparam int TAP_CNT_BITS   = 2;

    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 5;

    localparam logic [BUF_LEN_BITS-1:0] BUF_LEN_RESET = BUF_LEN_BITS'(48000);
    localparam logic [TAP_CNT_BITS-1:0] TAP_CNT_RESET = TAP_CNT_BITS'(1);
    localparam logic [DELAY_BITS-1:0]   DELAY_RESET   = '0;
    localparam logic [GAIN_BITS-1:0]    GAIN_RESET    = GAIN_BITS'(65536);

    typedef enum logic [2:0] {
        REG_BUFFER_LENGTH = 3'd0,
        REG_TAP_COUNT     = 3'd1,
        REG_DELAY_0       = 3'd2,
        REG_DELAY_1       = 3'd3,
        REG_DELAY_2       = 3'd4,
        REG_GAIN_0        = 3'd5,
        REG_GAIN_1        = 3'd6,
        REG_GAIN_2        = 3'd7
    } reg_index_t;

endpackage

// File: rtl/core/mtdl_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module mtdl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/core/multitap_delay_line.sv
// Multitap delay line: circular sample memory with up to three gained taps.
// Depends on mtdl_pkg for the register map and on mtdl_ram for the sample memory.
// A request is written, then each tap is clamped, addressed, read, multiplied and accumulated in turn, then saturated.
// A new request is taken only while the sequencer is idle, as the single multiplier and RAM
// read port are walked once per tap; a result not yet taken holds the sequencer back.
// Reset: registers return to their defaults; a fill count makes unwritten entries read as zero.
module multitap_delay_line
    import mtdl_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH,
    parameter int MAX_TAPS     = DEFAULT_MAX_TAPS,
    parameter int SAMPLE_BITS  = DEFAULT_SAMPLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Sample request channel.
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    // Result channel.
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_ADDR_BITS-1:0]      paddr,
    input  logic [APB_DATA_BITS-1:0]      pwdata,
    output logic [APB_DATA_BITS-1:0]      prdata,
    output logic                          pready
);

    // Address width of the memory, and a length width that can hold the depth.
    localparam int ADDR_W = $clog2(BUFFER_DEPTH);
    localparam int LEN_W  = ADDR_W + 1;
    // Comparison width wide enough for both the length register and the depth.
    localparam int CMP_W  = (LEN_W > BUF_LEN_BITS) ? LEN_W : BUF_LEN_BITS;
    // Product of a signed sample and an unsigned gain, and the sum of three.
    localparam int PROD_W = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int ACC_W  = PROD_W + 2;

    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    // The sequencer walks the taps one at a time through a single read port,
    // multiplier and accumulator.
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_WRITE = 8'b0000_0010,
        S_CLAMP = 8'b0000_0100,
        S_ADDR  = 8'b0000_1000,
        S_READ  = 8'b0001_0000,
        S_MUL   = 8'b0010_0000,
        S_ACC   = 8'b0100_0000,
        S_SAT   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Configuration registers.
    logic [BUF_LEN_BITS-1:0] buffer_length_reg;
    logic [TAP_CNT_BITS-1:0] tap_count_reg;
    logic [DELAY_BITS-1:0]   delay_reg [NUM_TAP_REGS];
    logic [GAIN_BITS-1:0]    gain_reg  [NUM_TAP_REGS];

    // Control state.
    logic [ADDR_W-1:0]       wp_reg;
    logic [LEN_W-1:0]        fill_reg;
    logic [1:0]              tap_idx_reg;
    logic                    out_valid_reg;

    // Per-request working registers.
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic [LEN_W-1:0]              len_reg;
    logic [TAP_CNT_BITS-1:0]       taps_reg;
    logic [ADDR_W-1:0]             wp_cur_reg;
    logic [ADDR_W-1:0]             dly_reg;
    logic [ADDR_W-1:0]             rd_addr_reg;
    logic                          rd_hit_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg;

    logic                    cfg_write;
    reg_index_t              cfg_idx;
    logic [CMP_W-1:0]        bl_ext;
    logic [LEN_W-1:0]        len_eff;
    logic [TAP_CNT_BITS-1:0] taps_eff;
    logic [CMP_W-1:0]        dly_ext;
    logic [CMP_W-1:0]        dly_lim;
    logic [LEN_W-1:0]        rd_sum;
    logic [LEN_W-1:0]        wp_inc;
    logic signed [SAMPLE_BITS-1:0] rd_data;
    logic signed [SAMPLE_BITS-1:0] mul_in;
    logic signed [ACC_W-1:0]       acc_shift;
    logic signed [SAMPLE_BITS-1:0] sat_val;
    logic                          last_tap;
    logic                          out_free;

    // ------------------------------------------------------------------
    // Configuration port. Writes complete in the access phase; pready is
    // tied high so no access has wait states.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = reg_index_t'(paddr[APB_ADDR_BITS-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_length_reg <= BUF_LEN_RESET;
            tap_count_reg     <= TAP_CNT_RESET;
            for (int k = 0; k < NUM_TAP_REGS; k++)
            begin
                delay_reg[k] <= DELAY_RESET;
                gain_reg[k]  <= GAIN_RESET;
            end
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_BUFFER_LENGTH: buffer_length_reg <= pwdata[BUF_LEN_BITS-1:0];
                REG_TAP_COUNT:     tap_count_reg     <= pwdata[TAP_CNT_BITS-1:0];
                REG_DELAY_0:       delay_reg[0]      <= pwdata[DELAY_BITS-1:0];
                REG_DELAY_1:       delay_reg[1]      <= pwdata[DELAY_BITS-1:0];
                REG_DELAY_2:       delay_reg[2]      <= pwdata[DELAY_BITS-1:0];
                REG_GAIN_0:        gain_reg[0]       <= pwdata[GAIN_BITS-1:0];
                REG_GAIN_1:        gain_reg[1]       <= pwdata[GAIN_BITS-1:0];
                REG_GAIN_2:        gain_reg[2]       <= pwdata[GAIN_BITS-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_BUFFER_LENGTH: prdata = APB_DATA_BITS'(buffer_length_reg);
            REG_TAP_COUNT:     prdata = APB_DATA_BITS'(tap_count_reg);
            REG_DELAY_0:       prdata = APB_DATA_BITS'(delay_reg[0]);
            REG_DELAY_1:       prdata = APB_DATA_BITS'(delay_reg[1]);
            REG_DELAY_2:       prdata = APB_DATA_BITS'(delay_reg[2]);
            REG_GAIN_0:        prdata = APB_DATA_BITS'(gain_reg[0]);
            REG_GAIN_1:        prdata = APB_DATA_BITS'(gain_reg[1]);
            REG_GAIN_2:        prdata = APB_DATA_BITS'(gain_reg[2]);
        endcase
    end

    // ------------------------------------------------------------------
    // Effective length and tap count. A zero length or tap count acts as
    // one, and values above what the hardware holds are clamped.
    // ------------------------------------------------------------------
    assign bl_ext = CMP_W'(buffer_length_reg);

    always_comb
    begin
        priority if (bl_ext == '0)
            len_eff = LEN_W'(1);
        else if (bl_ext > CMP_W'(BUFFER_DEPTH))
            len_eff = LEN_W'(BUFFER_DEPTH);
        else
            len_eff = LEN_W'(bl_ext);
    end

    always_comb
    begin
        priority if (tap_count_reg == '0)
            taps_eff = TAP_CNT_BITS'(1);
        else if (tap_count_reg > TAP_CNT_BITS'(MAX_TAPS))
            taps_eff = TAP_CNT_BITS'(MAX_TAPS);
        else
            taps_eff = tap_count_reg;
    end

    // ------------------------------------------------------------------
    // Per-tap datapath. A delay is clamped to length minus one, and the read
    // address wraps around the active part of the buffer. Since the write
    // position always counts up from zero, written entries form a prefix of
    // the memory; an address at or above the fill count reads as zero.
    // ------------------------------------------------------------------
    assign dly_ext = CMP_W'(delay_reg[tap_idx_reg]);
    assign dly_lim = CMP_W'(len_reg) - CMP_W'(1);
    assign rd_sum  = ({1'b0, wp_cur_reg} >= {1'b0, dly_reg})
                   ? ({1'b0, wp_cur_reg} - {1'b0, dly_reg})
                   : ({1'b0, wp_cur_reg} + len_reg - {1'b0, dly_reg});
    assign wp_inc  = {1'b0, wp_cur_reg} + LEN_W'(1);
    assign mul_in  = rd_hit_reg ? rd_data : '0;
    assign last_tap = (tap_idx_reg == 2'(taps_reg - TAP_CNT_BITS'(1)));

    // Floor division by the gain scale is an arithmetic shift.
    assign acc_shift = acc_reg >>> GAIN_FRAC_BITS;

    always_comb
    begin
        priority if (acc_shift > SAT_HI)
            sat_val = SAT_HI[SAMPLE_BITS-1:0];
        else if (acc_shift < SAT_LO)
            sat_val = SAT_LO[SAMPLE_BITS-1:0];
        else
            sat_val = acc_shift[SAMPLE_BITS-1:0];
    end

    mtdl_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (BUFFER_DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (state_reg == S_WRITE),
        .wr_addr (wp_cur_reg),
        .wr_data (sample_reg),
        .rd_en   (state_reg == S_READ),
        .rd_addr (rd_addr_reg),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_WRITE;
            S_WRITE: state_next = S_CLAMP;
            S_CLAMP: state_next = S_ADDR;
            S_ADDR:  state_next = S_READ;
            S_READ:  state_next = S_MUL;
            S_MUL:   state_next = S_ACC;
            S_ACC:   state_next = last_tap ? S_SAT : S_CLAMP;
            S_SAT:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            fill_reg      <= '0;
            tap_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == S_WRITE)
            begin
                tap_idx_reg <= '0;
                if ({1'b0, wp_cur_reg} == fill_reg)
                begin
                    fill_reg <= fill_reg + LEN_W'(1);
                end
            end
            else if (state_reg == S_ACC && !last_tap)
            begin
                tap_idx_reg <= tap_idx_reg + 2'd1;
            end

            if (state_reg == S_SAT && out_free)
            begin
                out_valid_reg <= 1'b1;
                wp_reg <= (wp_inc >= len_reg) ? '0 : wp_inc[ADDR_W-1:0];
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                sample_reg <= sample_in;
                len_reg    <= len_eff;
                taps_reg   <= taps_eff;
                // A write position left beyond a shortened buffer restarts at zero.
                wp_cur_reg <= ({1'b0, wp_reg} >= len_eff) ? '0 : wp_reg;
            end
            S_WRITE:
            begin
                acc_reg <= '0;
            end
            S_CLAMP:
            begin
                dly_reg <= (dly_ext > dly_lim) ? dly_lim[ADDR_W-1:0] : dly_ext[ADDR_W-1:0];
            end
            S_ADDR:
            begin
                rd_addr_reg <= rd_sum[ADDR_W-1:0];
            end
            S_READ:
            begin
                rd_hit_reg <= ({1'b0, rd_addr_reg} < fill_reg);
            end
            S_MUL:
            begin
                prod_reg <= mul_in * $signed({1'b0, gain_reg[tap_idx_reg]});
            end
            S_ACC:
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
            S_SAT:
            begin
                if (out_free)
                begin
                    sample_out_reg <= sat_val;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

endmodule

// File: test/multitap_delay_line_test.sv
// Self-checking testbench for multitap_delay_line: drives sample requests, programs the
// registers over the APB port and checks every output sample against an in-bench predictor.
// Depends on mtdl_pkg and multitap_delay_line only.
module multitap_delay_line_test
    import mtdl_pkg::*;
();

    localparam int MEM_DEPTH     = DEFAULT_BUFFER_DEPTH;
    localparam int MAX_ECHOES    = DEFAULT_MAX_TAPS;
    localparam int SAMPLE_W      = DEFAULT_SAMPLE_BITS;
    // Settling wait after the last result, before the registers are written again.
    localparam int SETTLE_CYCLES = 24;
    localparam int LONG_HOLD     = 500;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_PHASES = 14;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    sample_t                  sample_in = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    sample_t                  sample_out;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    multitap_delay_line u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample_in (sample_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sample_out(sample_out),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Shadow copy of the register file. It only changes while the block is idle, so the
    // predictor can read it at the moment a request is accepted.
    logic [BUF_LEN_BITS-1:0] cfg_buffer_length = BUF_LEN_RESET;
    logic [TAP_CNT_BITS-1:0] cfg_echo_count    = TAP_CNT_RESET;
    logic [DELAY_BITS-1:0]   cfg_delay [NUM_TAP_REGS] = '{default: DELAY_RESET};
    logic [GAIN_BITS-1:0]    cfg_gain  [NUM_TAP_REGS] = '{default: GAIN_RESET};

    // Predicted sample memory and write pointer. Reset leaves the memory all zero.
    sample_t     echo_mem [MEM_DEPTH] = '{default: '0};
    int unsigned write_pos = 0;

    sample_t expected_samples [$];  // predicted outputs, oldest first
    sample_t pending_samples [$];   // requests waiting for the driver
    sample_t staged_samples [$];    // requests of the phase being built

    int  requests_queued = 0;
    int  results_seen = 0;
    int  fail_count = 0;
    int  cycle_count = 0;
    int  burst_left = 1;
    int  gap_left = 0;
    int  hold_left = 0;
    int  hold_trigger = 0;
    int  hold_seen = 0;
    logic [7:0] ready_pattern = 8'b1011_0110;
    logic sample_taken = 1'b0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Predicts the output sample for one accepted request and advances the predicted state.
    // The write lands first, so a zero delay reads the request's own sample back.
    function automatic sample_t predict_echo_sum(input sample_t x);
        int unsigned len;
        int unsigned echoes;
        int unsigned lag;
        int unsigned rd;
        longint      acc;
        longint      q;
        len = cfg_buffer_length;
        if (len < 1)
            len = 1;
        if (len > MEM_DEPTH)
            len = MEM_DEPTH;
        echoes = cfg_echo_count;
        if (echoes < 1)
            echoes = 1;
        if (echoes > MAX_ECHOES)
            echoes = MAX_ECHOES;
        // A shortened buffer can leave the pointer beyond its end; it restarts at zero.
        if (write_pos >= len)
            write_pos = 0;
        echo_mem[write_pos] = x;
        acc = 0;
        for (int k = 0; k < int'(echoes); k++)
        begin
            lag = cfg_delay[k];
            if (lag > len - 1)
                lag = len - 1;
            rd = (write_pos >= lag) ? write_pos - lag : write_pos + len - lag;
            acc = acc + longint'(echo_mem[rd]) * longint'(cfg_gain[k]);
        end
        // Arithmetic shift floors negative sums, then the result saturates to the sample range.
        q = acc >>> GAIN_FRAC_BITS;
        if (q > longint'(2 ** (SAMPLE_W - 1) - 1))
            q = 2 ** (SAMPLE_W - 1) - 1;
        if (q < -longint'(2 ** (SAMPLE_W - 1)))
            q = -longint'(2 ** (SAMPLE_W - 1));
        write_pos = write_pos + 1;
        if (write_pos >= len)
            write_pos = 0;
        return sample_t'(q);
    endfunction

    // Fills the bits above a register's width with junk now and then; the block must drop them.
    function automatic logic [APB_DATA_BITS-1:0] padded(input int unsigned v, input int width);
        logic [APB_DATA_BITS-1:0] junk;
        junk = ($urandom_range(0, 3) == 0) ? APB_DATA_BITS'($urandom) << width : '0;
        return junk | APB_DATA_BITS'(v);
    endfunction

    task automatic note_failure(input string msg);
        fail_count = fail_count + 1;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    // One APB write: a setup phase, then an access phase that completes on pready.
    task automatic write_reg(input reg_index_t idx, input logic [APB_DATA_BITS-1:0] data);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = APB_ADDR_BITS'(idx) << 2;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_BUFFER_LENGTH: cfg_buffer_length = data[BUF_LEN_BITS-1:0];
            REG_TAP_COUNT:     cfg_echo_count = data[TAP_CNT_BITS-1:0];
            REG_DELAY_0:       cfg_delay[0] = data[DELAY_BITS-1:0];
            REG_DELAY_1:       cfg_delay[1] = data[DELAY_BITS-1:0];
            REG_DELAY_2:       cfg_delay[2] = data[DELAY_BITS-1:0];
            REG_GAIN_0:        cfg_gain[0] = data[GAIN_BITS-1:0];
            REG_GAIN_1:        cfg_gain[1] = data[GAIN_BITS-1:0];
            REG_GAIN_2:        cfg_gain[2] = data[GAIN_BITS-1:0];
            default:           ;
        endcase
    endtask

    // Hands the staged requests to the driver just after a rising edge, where the driver
    // never touches its queue, then waits until every result is back and the
    // block has had time to go quiet. Register writes are only safe after this returns.
    task automatic play_staged();
        @(posedge clk);
        requests_queued = requests_queued + staged_samples.size();
        while (staged_samples.size() > 0)
            pending_samples.push_back(staged_samples.pop_front());
        while (results_seen != requests_queued)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // Sender. A request stays on the bus until the monitor saw it accepted. Between requests
    // the sender works in bursts, with random gaps that land on every phase of the block's
    // sequencer, and bursts with no gap at all.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || sample_taken)
        begin
            if (in_valid && burst_left > 0)
                burst_left = burst_left - 1;
            if (in_valid && burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            end
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_samples.size() > 0)
            begin
                sample_in <= pending_samples.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver. It normally follows a rotating stall pattern that is reloaded now and then,
    // either with all ones (no stalls) or with random bits. When the stimulus asks for it,
    // the receiver instead holds off for a long stretch so that the block backs up and has
    // to refuse further requests.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (hold_seen != hold_trigger)
        begin
            hold_seen = hold_trigger;
            hold_left = LONG_HOLD;
            out_ready <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 47) == 0)
                ready_pattern = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'($urandom);
            ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
            out_ready <= ready_pattern[0];
        end
    end

    // Monitor. Accepted requests feed the predictor; accepted results are checked against
    // the oldest prediction. Both handshakes are sampled at the rising edge.
    always @(posedge clk)
    begin
        sample_t want;
        if (!rst_n)
        begin
            sample_taken <= 1'b0;
        end
        else
        begin
            sample_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
                expected_samples.push_back(predict_echo_sum(sample_in));
            if (out_valid && out_ready)
            begin
                results_seen = results_seen + 1;
                if (expected_samples.size() == 0)
                begin
                    note_failure($sformatf("result %0d: sample_out %0d with no request pending",
                        results_seen, sample_out));
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (sample_out !== want)
                        note_failure($sformatf("result %0d: sample_out expected %0d, got %0d",
                            results_seen, want, sample_out));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[multitap_delay_line] ERROR");
            $finish;
        end
    end

    initial
    begin
        int unsigned len;
        int unsigned span;
        int unsigned dv;
        int unsigned gv;
        int          count;
        int          choice;

        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: one echo, zero delay, unity gain, so each sample comes straight
        // back. The field extremes go through unchanged.
        staged_samples = '{24'sh7FFFFF, 24'sh800000, 24'sd0, -24'sd1, 24'sd1};
        play_staged();

        // Four-sample buffer with all three echoes at full gain: sums saturate both ways.
        // The third delay is longer than the buffer and gets clamped. The write pointer
        // sits beyond the new buffer end, so it restarts at zero.
        write_reg(REG_BUFFER_LENGTH, 32'd4);
        write_reg(REG_TAP_COUNT, 32'd3);
        write_reg(REG_DELAY_0, 32'd0);
        write_reg(REG_DELAY_1, 32'd1);
        write_reg(REG_DELAY_2, 32'd9);
        write_reg(REG_GAIN_0, 32'hFFFFF);
        write_reg(REG_GAIN_1, 32'hFFFFF);
        write_reg(REG_GAIN_2, 32'hFFFFF);
        staged_samples = '{24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sd1000, -24'sd5,
            24'sd7, 24'sd3};
        play_staged();

        // Buffer shrunk to two while the pointer is past its end, memory kept from before;
        // an echo count of zero acts as one, and half gain floors odd negative samples.
        write_reg(REG_BUFFER_LENGTH, 32'd2);
        write_reg(REG_TAP_COUNT, 32'd0);
        write_reg(REG_DELAY_0, 32'd1);
        write_reg(REG_GAIN_0, 32'd32768);
        staged_samples = '{-24'sd3, 24'sd5, -24'sd1, 24'sh7FFFFF};
        play_staged();

        // A zero buffer length acts as one, so every delay clamps to zero.
        write_reg(REG_BUFFER_LENGTH, 32'd0);
        write_reg(REG_TAP_COUNT, 32'd3);
        write_reg(REG_DELAY_0, 32'd65535);
        write_reg(REG_DELAY_1, 32'd65535);
        write_reg(REG_DELAY_2, 32'd65535);
        write_reg(REG_GAIN_0, 32'd0);
        write_reg(REG_GAIN_1, 32'd65536);
        write_reg(REG_GAIN_2, 32'hFFFFF);
        staged_samples = '{24'sd12345, -24'sd2, 24'sh800000};
        play_staged();

        // The largest buffer length field acts as the full memory; the longest delay
        // reaches almost all the way round it.
        write_reg(REG_BUFFER_LENGTH, 32'h1FFFF);
        write_reg(REG_TAP_COUNT, 32'd2);
        write_reg(REG_DELAY_0, 32'd65535);
        write_reg(REG_DELAY_1, 32'd0);
        write_reg(REG_GAIN_0, 32'd65536);
        write_reg(REG_GAIN_1, 32'd65536);
        staged_samples = '{24'sd100, -24'sd100, 24'sd77};
        play_staged();

        // Random phases. Short buffers dominate so that the pointer wraps many times and
        // the delays read back real data; the extremes of every register turn up as well.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            choice = $urandom_range(0, 9);
            case (choice)
                0:       len = 0;
                1:       len = 1;
                2:       len = MEM_DEPTH;
                3:       len = $urandom_range(MEM_DEPTH + 1, 2 ** BUF_LEN_BITS - 1);
                4:       len = $urandom_range(100, MEM_DEPTH - 1);
                default: len = $urandom_range(2, 48);
            endcase
            write_reg(REG_BUFFER_LENGTH, padded(len, BUF_LEN_BITS));
            write_reg(REG_TAP_COUNT, padded($urandom_range(0, 3), TAP_CNT_BITS));
            span = (len < 1) ? 1 : (len > MEM_DEPTH) ? MEM_DEPTH : len;
            span = (span + 2 > 65535) ? 65535 : span + 2;
            for (int k = 0; k < NUM_TAP_REGS; k++)
            begin
                case ($urandom_range(0, 7))
                    0:       dv = 0;
                    1:       dv = 65535;
                    2:       dv = $urandom_range(0, 65535);
                    default: dv = $urandom_range(0, span);
                endcase
                case ($urandom_range(0, 7))
                    0:       gv = 0;
                    1:       gv = 2 ** GAIN_BITS - 1;
                    2:       gv = 65536;
                    3:       gv = $urandom_range(0, 2 ** GAIN_BITS - 1);
                    default: gv = $urandom_range(0, 98304);
                endcase
                write_reg(reg_index_t'(int'(REG_DELAY_0) + k), padded(dv, DELAY_BITS));
                write_reg(reg_index_t'(int'(REG_GAIN_0) + k), padded(gv, GAIN_BITS));
            end

            count = (phase == 3) ? 160 : $urandom_range(70, 130);
            for (int n = 0; n < count; n++)
            begin
                case ($urandom_range(0, 7))
                    0:       staged_samples.push_back(24'sh7FFFFF);
                    1:       staged_samples.push_back(24'sh800000);
                    2:       staged_samples.push_back(sample_t'(int'($urandom_range(0, 15)) - 8));
                    default: staged_samples.push_back(sample_t'($urandom));
                endcase
            end

            // In one phase the receiver stops for a long stretch while requests keep coming.
            if (phase == 3)
            begin
                @(posedge clk);
                hold_trigger = hold_trigger + 1;
            end
            play_staged();
        end

        if (expected_samples.size() != 0)
            note_failure($sformatf("%0d predicted samples never came out",
                expected_samples.size()));

        if (fail_count == 0)
            $display("[multitap_delay_line] OK");
        else
            $display("[multitap_delay_line] ERROR");
        $finish;
    end

endmodule
